// ===== hdl/ntcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ntcs_pkg
// Shared types and constants for the nearest target cost search block.
// ----------------------------------------------------------------------------
package ntcs_pkg;

  localparam int unsigned MaxTargets = 16;
  localparam int unsigned CntW       = $clog2(MaxTargets + 1);
  localparam int unsigned CoordW     = 32;
  localparam int unsigned LayerW     = 6;
  localparam int unsigned ViaW       = 24;
  localparam int unsigned CostW      = 34;
  localparam int unsigned DistW      = 33;
  localparam int unsigned SqW        = 66;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CostW-1:0]         cost_t;
  typedef logic [SqW-1:0]           sq_t;

  // Query token flowing through the cell row.
  typedef struct packed {
    logic                 vld;
    coord_t               px;
    coord_t               py;
    logic [LayerW-1:0]    lay;
    logic                 have;
    cost_t                best_cost;
    sq_t                  best_sq;
    coord_t               nx;
    coord_t               ny;
    logic                 at;
  } tok_t;

  // Target written into one cell.
  typedef struct packed {
    coord_t            cx;
    coord_t            cy;
    logic [LayerW-1:0] lay;
    coord_t            bx0;
    coord_t            by0;
    coord_t            bx1;
    coord_t            by1;
  } tgt_t;

endpackage

// ===== hdl/ntcs_cell.sv =====
// ----------------------------------------------------------------------------
// ntcs_cell
// One target slot. Holds a target and folds it into the passing query token
// over two register stages (distances/squares, then compare).
// ----------------------------------------------------------------------------
module ntcs_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  ntcs_pkg::tgt_t  tgt_i,
  input  logic            live_i,
  input  logic [23:0]     via_i,
  input  ntcs_pkg::tok_t  tok_i,
  output ntcs_pkg::tok_t  tok_o
);
  import ntcs_pkg::*;

  tgt_t                tgt_q;
  tok_t                s1_q, tok_q, tok_d;
  logic                s1_vld_q, tok_vld_q;
  logic                s1_live_q, s1_in_q;
  logic [DistW-1:0]    dx_q, dy_q;
  logic [CostW-1:0]    lcost_q, lcost_d;
  logic [SqW-2:0]      sqx_q, sqy_q;
  logic [2*CoordW-1:0] sqx_d, sqy_d;
  logic [DistW-1:0]    dx_d, dy_d;
  logic [LayerW-1:0]   ld_d;
  logic                inx_d, iny_d;
  cost_t               c_d;
  sq_t                 sq_d;

  function automatic logic [DistW-1:0] adiff(coord_t a, coord_t b);
    logic signed [DistW-1:0] d;
    d = DistW'(a) - DistW'(b);
    return d[DistW-1] ? DistW'(-d) : DistW'(d);
  endfunction

  function automatic logic btw(coord_t v, coord_t e0, coord_t e1);
    return (e0 < e1) ? (v >= e0 && v <= e1) : (v >= e1 && v <= e0);
  endfunction

  always_comb begin
    dx_d    = adiff(tok_i.px, tgt_q.cx);
    dy_d    = adiff(tok_i.py, tgt_q.cy);
    ld_d    = (tok_i.lay >= tgt_q.lay) ? tok_i.lay - tgt_q.lay : tgt_q.lay - tok_i.lay;
    inx_d   = btw(tok_i.px, tgt_q.bx0, tgt_q.bx1);
    iny_d   = btw(tok_i.py, tgt_q.by0, tgt_q.by1);
    lcost_d = CostW'(ld_d) * CostW'(via_i);
    sqx_d   = (2*CoordW)'(dx_d[CoordW-1:0]) * (2*CoordW)'(dx_d[CoordW-1:0]);
    sqy_d   = (2*CoordW)'(dy_d[CoordW-1:0]) * (2*CoordW)'(dy_d[CoordW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      tgt_q <= tgt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= tok_i.vld;
      tok_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= tok_i;
    s1_live_q <= live_i;
    s1_in_q   <= (tgt_q.lay == tok_i.lay) && inx_d && iny_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    lcost_q   <= lcost_d;
    sqx_q     <= (SqW-1)'(sqx_d);
    sqy_q     <= (SqW-1)'(sqy_d);
    tok_q     <= tok_d;
  end

  always_comb begin
    c_d   = CostW'(dx_q) + CostW'(dy_q) + lcost_q;
    sq_d  = SqW'(sqx_q) + SqW'(sqy_q);
    tok_d = s1_q;
    if (s1_live_q) begin
      tok_d.have = 1'b1;
      if (!s1_q.have || c_d < s1_q.best_cost) tok_d.best_cost = c_d;
      if (!s1_q.have || sq_d < s1_q.best_sq) begin
        tok_d.best_sq = sq_d;
        tok_d.nx      = tgt_q.cx;
        tok_d.ny      = tgt_q.cy;
      end
      tok_d.at = s1_q.at | s1_in_q;
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

endmodule

// ===== hdl/nearest_target_cost_search_top.sv =====
// ----------------------------------------------------------------------------
// nearest_target_cost_search_top
// Target table as a row of cells; queries ripple through the row.
// ----------------------------------------------------------------------------
// channel | dir | handshake
// in      | in  | in_valid_i / in_stall_o
// out     | out | out_valid_o / out_stall_i
// cfg     | in  | cfg_valid_i / cfg_ready_o
// Clear, add and ignored modes go straight to the output register. A query
// passes two register stages per cell of the row and then the output
// register. One item is in flight at a time; the output register holds a
// result until it is taken, and the next item is accepted in the cycle that
// result transfers or later. Reset empties the table and zeroes via_cost.
module nearest_target_cost_search_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  input  logic signed [31:0]   pt_x_i,
  input  logic signed [31:0]   pt_y_i,
  input  logic [5:0]           layer_i,
  input  logic signed [31:0]   box_min_x_i,
  input  logic signed [31:0]   box_min_y_i,
  input  logic signed [31:0]   box_max_x_i,
  input  logic signed [31:0]   box_max_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [33:0]          cost_o,
  output logic                 at_target_o,
  output logic signed [31:0]   nearest_x_o,
  output logic signed [31:0]   nearest_y_o,
  output logic                 table_full_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [23:0]          cfg_data_i
);
  import ntcs_pkg::*;

  logic [ViaW-1:0] via_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            in_acc, out_acc;
  tok_t            tok [MaxTargets+1];
  tok_t            tok_head;
  tgt_t            tgt_new;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q | (out_valid_o & out_stall_i);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_o & ~out_stall_i;

  assign tgt_new = '{cx: pt_x_i, cy: pt_y_i, lay: layer_i, bx0: box_min_x_i,
                     by0: box_min_y_i, bx1: box_max_x_i, by1: box_max_y_i};

  always_comb begin
    tok_head         = '0;
    tok_head.vld     = in_acc && (mode_i == MODE_QUERY);
    tok_head.px      = pt_x_i;
    tok_head.py      = pt_y_i;
    tok_head.lay     = layer_i;
    tok_head.nx      = pt_x_i;
    tok_head.ny      = pt_y_i;
  end

  assign tok[0] = tok_head;

  for (genvar g = 0; g < MaxTargets; g++) begin : g_cell
    ntcs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (in_acc && mode_i == MODE_ADD && cnt_q == CntW'(g)),
      .tgt_i  (tgt_new),
      .live_i (cnt_q > CntW'(g)),
      .via_i  (via_q),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      via_q       <= '0;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) via_q <= cfg_data_i;
      if ((in_acc && mode_i != MODE_QUERY) || tok[MaxTargets].vld) begin
        out_valid_o <= 1'b1;
      end else if (out_acc) begin
        out_valid_o <= 1'b0;
      end
      if (in_acc && mode_i == MODE_QUERY) begin
        busy_q <= 1'b1;
      end else if (tok[MaxTargets].vld) begin
        busy_q <= 1'b0;
      end
      if (in_acc) begin
        if (mode_i == MODE_CLEAR) cnt_q <= '0;
        if (mode_i == MODE_ADD && cnt_q < CntW'(MaxTargets)) cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cost_o       <= '0;
      at_target_o  <= 1'b0;
      nearest_x_o  <= '0;
      nearest_y_o  <= '0;
      table_full_o <= (mode_i == MODE_ADD) && (cnt_q >= CntW'(MaxTargets));
    end else if (tok[MaxTargets].vld) begin
      cost_o       <= tok[MaxTargets].best_cost;
      at_target_o  <= tok[MaxTargets].at;
      nearest_x_o  <= tok[MaxTargets].nx;
      nearest_y_o  <= tok[MaxTargets].ny;
      table_full_o <= 1'b0;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_acc) else $error("accept while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxTargets)) else $error("count overflow");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MaxTargets].vld |-> busy_q) else $error("stray query result");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_target_cost_search_top: a queue-fed driver,
// a monitor comparing each result transfer against a predicted target table.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ntcs_pkg::*;

  typedef struct {
    mode_e       mode;
    logic [31:0] px, py;
    logic [5:0]  lay;
    logic [31:0] b0x, b0y, b1x, b1y;
  } item_t;

  typedef struct {
    logic [33:0] cost;
    logic        at;
    logic [31:0] nx, ny;
    logic        full;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = '0;
  logic signed [31:0] pt_x_i = '0, pt_y_i = '0;
  logic [5:0] layer_i = '0;
  logic signed [31:0] box_min_x_i = '0, box_min_y_i = '0, box_max_x_i = '0, box_max_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [33:0] cost_o;
  logic at_target_o, table_full_o;
  logic signed [31:0] nearest_x_o, nearest_y_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [23:0] cfg_data_i = '0;

  nearest_target_cost_search_top uut (.*);

  always #6 clk_i = ~clk_i;

  item_t pending_items[$];
  res_t  expected_results[$];
  int    mismatches = 0;
  int    results_seen = 0;
  bit    idle_free = 1'b0;
  int    hold_off = 0;
  longint cycles = 0;

  // predicted table
  logic [23:0] via_cost_m = '0;
  int          tgt_count = 0;
  logic signed [31:0] tcx[MaxTargets], tcy[MaxTargets];
  logic [5:0]  tlay[MaxTargets];
  logic signed [31:0] tb0x[MaxTargets], tb0y[MaxTargets], tb1x[MaxTargets], tb1y[MaxTargets];

  function automatic logic [32:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [33:0] d;
    d = 34'(a) - 34'(b);
    return (d < 0) ? 33'(-d) : 33'(d);
  endfunction

  function automatic bit in_span(logic signed [31:0] v, logic signed [31:0] e0,
                                 logic signed [31:0] e1);
    logic signed [31:0] lo, hi;
    lo = (e0 < e1) ? e0 : e1;
    hi = (e0 < e1) ? e1 : e0;
    return v >= lo && v <= hi;
  endfunction

  function automatic res_t predict_search(item_t it);
    res_t r;
    logic [32:0] dx, dy;
    logic [5:0] ld;
    logic [33:0] c, best_c;
    logic [65:0] sq, best_sq;
    r = '{default: '0};
    case (it.mode)
      MODE_CLEAR: tgt_count = 0;
      MODE_ADD: begin
        if (tgt_count >= MaxTargets) begin
          r.full = 1'b1;
        end else begin
          tcx[tgt_count] = it.px; tcy[tgt_count] = it.py; tlay[tgt_count] = it.lay;
          tb0x[tgt_count] = it.b0x; tb0y[tgt_count] = it.b0y;
          tb1x[tgt_count] = it.b1x; tb1y[tgt_count] = it.b1y;
          tgt_count++;
        end
      end
      MODE_QUERY: begin
        r.nx = it.px;
        r.ny = it.py;
        best_c = '1;
        best_sq = '1;
        for (int i = 0; i < tgt_count; i++) begin
          dx = abs_diff(it.px, tcx[i]);
          dy = abs_diff(it.py, tcy[i]);
          ld = (it.lay >= tlay[i]) ? it.lay - tlay[i] : tlay[i] - it.lay;
          c = 34'(dx) + 34'(dy) + 34'(ld) * 34'(via_cost_m);
          sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
          if (c < best_c) best_c = c;
          if (i == 0 || sq < best_sq) begin
            best_sq = sq;
            r.nx = tcx[i];
            r.ny = tcy[i];
          end
          if (tlay[i] == it.lay && in_span(it.px, tb0x[i], tb1x[i]) &&
              in_span(it.py, tb0y[i], tb1y[i])) r.at = 1'b1;
        end
        if (tgt_count > 0) r.cost = best_c;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() > 0 && (idle_free || $urandom_range(99) >= 32)) begin
          item_t it;
          it = pending_items.pop_front();
          expected_results.insert(expected_results.size(), predict_search(it));
          in_valid_i <= 1'b1;
          mode_i <= it.mode; pt_x_i <= it.px; pt_y_i <= it.py; layer_i <= it.lay;
          box_min_x_i <= it.b0x; box_min_y_i <= it.b0y;
          box_max_x_i <= it.b1x; box_max_y_i <= it.b1y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !idle_free && ($urandom_range(99) < 32);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      res_t e;
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer cost=%0h", cost_o);
      end else begin
        e = expected_results.pop_front();
        if (cost_o !== e.cost || at_target_o !== e.at || nearest_x_o !== e.nx ||
            nearest_y_o !== e.ny || table_full_o !== e.full) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp cost=%0h at=%0b nx=%0h ny=%0h full=%0b,",
                      " got %0h %0b %0h %0h %0b"},
                     e.cost, e.at, e.nx, e.ny, e.full,
                     cost_o, at_target_o, nearest_x_o, nearest_y_o, table_full_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 2000000) begin
      $display("[nearest_target_cost_search_top] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom;
      default: return 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  function automatic item_t rand_item(mode_e m);
    item_t it;
    it.mode = m;
    it.px = rand_coord(); it.py = rand_coord();
    it.lay = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(3));
    it.b0x = rand_coord(); it.b0y = rand_coord();
    it.b1x = rand_coord(); it.b1y = rand_coord();
    if (m == MODE_ADD && $urandom_range(1)) begin
      it.b0x = it.px - $urandom_range(20); it.b1x = it.px + $urandom_range(20);
      it.b0y = it.py + $urandom_range(20); it.b1y = it.py - $urandom_range(20);
    end
    return it;
  endfunction

  task automatic write_via_cost(logic [23:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    via_cost_m = v;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (2 * MaxTargets + 4) @(posedge clk_i);
  endtask

  task automatic push(mode_e m, logic [31:0] x, logic [31:0] y, logic [5:0] l,
                      logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    pending_items.insert(pending_items.size(), '{m, x, y, l, a, b, c, d});
  endtask

  initial begin
    logic [23:0] via_settings[4] = '{24'd0, 24'hffffff, 24'd7, 24'd1000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_via_cost(24'hffffff);
    // directed
    push(MODE_QUERY, 32'd5, -32'sd7, 6'd3, 0, 0, 0, 0);
    push(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 6'd0,
         32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    push(MODE_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 6'd63, 0, 0, 0, 0);
    push(MODE_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 6'd0, 0, 0, 0, 0);
    push(MODE_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 6'd63, 0, 0, 0, 0);
    push(MODE_QUERY, 32'd0, 32'd0, 6'd63, 0, 0, 0, 0);
    push(MODE_QUERY, -32'sd1, -32'sd1, 6'd0, 0, 0, 0, 0);
    push(MODE_NONE, 32'hffff_ffff, 32'hffff_ffff, 6'd63, '1, '1, '1, '1);
    push(MODE_CLEAR, 0, 0, 6'd0, 0, 0, 0, 0);
    push(MODE_ADD, 32'd10, 32'd0, 6'd2, 32'd0, 32'd0, 32'd0, 32'd0);
    push(MODE_ADD, -32'sd10, 32'd0, 6'd2, 32'd0, 32'd0, 32'd0, 32'd0);
    push(MODE_QUERY, 32'd0, 32'd0, 6'd2, 0, 0, 0, 0);
    push(MODE_QUERY, 32'd0, 32'd0, 6'd1, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++) push(MODE_ADD, i, i, 6'(i), -i, -i, i, i);
    push(MODE_QUERY, 32'd3, 32'd3, 6'd3, 0, 0, 0, 0);
    drain();
    // random phases, one per via cost setting
    for (int p = 0; p < 4; p++) begin
      write_via_cost(via_settings[p]);
      idle_free = (p == 2);
      for (int n = 0; n < 260; n++) begin
        int r;
        r = $urandom_range(99);
        if (r < 3) pending_items.insert(pending_items.size(), rand_item(MODE_CLEAR));
        else if (r < 5) pending_items.insert(pending_items.size(), rand_item(MODE_NONE));
        else if (r < 45) pending_items.insert(pending_items.size(), rand_item(MODE_ADD));
        else pending_items.insert(pending_items.size(), rand_item(MODE_QUERY));
      end
      if (p == 1) begin
        repeat (20) @(posedge clk_i);
        hold_off = 300;
      end
      drain();
    end
    $display("covered %0d result transfers over four via cost settings, incl. full table",
             results_seen);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("[nearest_target_cost_search_top] OK");
    else
      $display("[nearest_target_cost_search_top] ERROR");
    $finish;
  end
endmodule
